/* rtl/core/sitda_pkg.sv */
// shared constants for the signed integer to decimal ascii converter
package sitda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int BITS_PER_STAGE = 4;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ   = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;

    // decimal digits needed for any magnitude up to 2**(bits-1)
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

/* rtl/core/sitda_absval.sv */
// input stage: sign and unsigned magnitude of the incoming value
module sitda_absval import sitda_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int PW         = VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_neg,
    output logic        [PW-1:0]         o_mag
);

    logic                  r_valid;
    logic                  r_neg;
    logic [PW-1:0]         r_mag;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] n_abs;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;

    always_comb begin
        n_neg = i_value[VALUE_BITS-1];
        n_abs = n_neg ? (~i_value + 1'b1) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= n_neg;
            r_mag <= PW'(n_abs);
        end
    end

endmodule

/* rtl/core/sitda_dabble.sv */
// one double dabble stage: shifts BITS_PER_STAGE (4) magnitude bits into the bcd digits
module sitda_dabble import sitda_pkg::*; #(
    parameter int ND = 10,
    parameter int PW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_neg,
    input  logic [ND*DIGIT_W-1:0] i_bcd,
    input  logic [PW-1:0]         i_mag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_neg,
    output logic [ND*DIGIT_W-1:0] o_bcd,
    output logic [PW-1:0]         o_mag
);

    localparam int BW = ND * DIGIT_W;

    logic          r_valid;
    logic          r_neg;
    logic [BW-1:0] r_bcd;
    logic [PW-1:0] r_mag;
    logic [BW-1:0] n_bcd;
    logic [PW-1:0] n_mag;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_mag   = r_mag;

    always_comb begin
        n_bcd = i_bcd;
        n_mag = i_mag;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < ND; d++) begin
                if (n_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
                    n_bcd[d*DIGIT_W +: DIGIT_W] = n_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
                end
            end
            {n_bcd, n_mag} = {n_bcd[BW-2:0], n_mag, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_mag <= n_mag;
        end
    end

endmodule

/* rtl/core/sitda_emit.sv */
// character serializer: optional minus sign, then digits without leading zeros
module sitda_emit import sitda_pkg::*; #(
    parameter int ND = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_neg,
    input  logic [ND*DIGIT_W-1:0] i_bcd,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_W-1:0]     o_char_code,
    output logic                  o_last
);

    localparam int IDXW = $clog2(ND);

    logic               r_busy;
    logic               r_sign_pend;
    logic [IDXW-1:0]    r_idx;
    logic [DIGIT_W-1:0] r_dig [ND];
    logic [IDXW-1:0]    n_hi;
    logic               w_final;
    logic               w_load;

    always_comb begin
        n_hi = '0;
        for (int k = 0; k < ND; k++) begin
            if (i_bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
                n_hi = IDXW'(k);
            end
        end
    end

    assign w_final = !r_sign_pend && (r_idx == '0);
    assign o_ready = !r_busy || (!i_stall && w_final);
    assign w_load  = o_ready && i_valid;

    assign o_valid     = r_busy;
    assign o_last      = w_final;
    assign o_char_code = r_sign_pend ? ASCII_MINUS
                                     : ASCII_ZERO + CHAR_W'(r_dig[r_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sign_pend <= 1'b0;
            r_idx       <= '0;
        end else if (w_load) begin
            r_busy      <= 1'b1;
            r_sign_pend <= i_neg;
            r_idx       <= n_hi;
        end else if (r_busy && !i_stall) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_idx == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int k = 0; k < ND; k++) begin
                r_dig[k] <= i_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// throughput: one character per cycle while i_stall is low; a value's text is 1 to 11 characters
// at 32 bits, all sent through the single character output port
// the stages ahead of the serializer take a value every cycle until all of them hold one
// reset: synchronous active low, clears all stage valid bits and the serializer
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic        [CHAR_W-1:0]     o_char_code,
    output logic                         o_last
);

    localparam int NSTG = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PW   = NSTG * BITS_PER_STAGE;
    localparam int ND   = num_digits(VALUE_BITS);
    localparam int BW   = ND * DIGIT_W;

    logic          w_valid [NSTG+1];
    logic          w_ready [NSTG+1];
    logic          w_neg   [NSTG+1];
    logic [BW-1:0] w_bcd   [NSTG+1];
    logic [PW-1:0] w_mag   [NSTG+1];
    logic          w_in_ready;

    assign o_stall  = !w_in_ready;
    assign w_bcd[0] = '0;

    sitda_absval #(
        .VALUE_BITS (VALUE_BITS),
        .PW         (PW)
    ) u_absval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_value (i_value),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_neg   (w_neg[0]),
        .o_mag   (w_mag[0])
    );

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        sitda_dabble #(
            .ND (ND),
            .PW (PW)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_neg   (w_neg[g]),
            .i_bcd   (w_bcd[g]),
            .i_mag   (w_mag[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_neg   (w_neg[g+1]),
            .o_bcd   (w_bcd[g+1]),
            .o_mag   (w_mag[g+1])
        );
    end

    sitda_emit #(
        .ND (ND)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[NSTG]),
        .o_ready     (w_ready[NSTG]),
        .i_neg       (w_neg[NSTG]),
        .i_bcd       (w_bcd[NSTG]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

`ifndef SYNTH
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_char_code != ASCII_MINUS)
        else $error("minus sign flagged as last character");

    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_char_code == ASCII_MINUS
        |=> o_valid && o_char_code != ASCII_ZERO && o_char_code != ASCII_MINUS)
        else $error("minus sign not followed by a nonzero leading digit");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_char_code == ASCII_MINUS
                    || (o_char_code >= ASCII_ZERO
                        && o_char_code <= ASCII_ZERO + CHAR_W'(DIGIT_NINE)))
        else $error("character code outside digit and minus set");
`endif

endmodule

/* bench/testbench.sv */
// self-checking testbench for the signed integer to decimal ascii converter
module testbench;
    import sitda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB             = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_ITEMS     = 60;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_dec_char;

    typedef struct {
        logic [VB-1:0] value;
        string         text;
    } t_dir_row;

    // empty text means the row is checked against the predictor
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{32'sd0,           "0"},
        '{32'sd1,           "1"},
        '{-32'sd1,          "-1"},
        '{32'sd9,           "9"},
        '{32'sd10,          "10"},
        '{-32'sd10,         "-10"},
        '{32'h7fff_ffff,    "2147483647"},
        '{32'h8000_0000,    "-2147483648"},
        '{-32'sd2147483647, "-2147483647"},
        '{32'sd1000000000,  "1000000000"},
        '{32'sd99,          ""},
        '{-32'sd100,        ""},
        '{32'sd12345,       ""},
        '{-32'sd987654321,  ""},
        '{-32'sd999999999,  ""},
        '{32'sd1999999999,  ""},
        '{32'h5555_5555,    ""},
        '{32'haaaa_aaaa,    ""},
        '{32'sd42,          ""},
        '{-32'sd7,          ""}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [VB-1:0] i_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [CHAR_W-1:0]    o_char_code;
    logic                 o_last;

    t_dec_char expected_chars [$];
    int        error_count;
    int        values_sent;
    int        negatives_sent;
    int        full_width_sent;
    int        chars_checked;
    int        hold_offs;
    int        drain_pauses;
    int        burst_left;
    bit        hold_off_req;

    signed_int_to_decimal_ascii #(.VALUE_BITS(VB)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_decimal_text(input logic [VB-1:0] v);
        logic          neg;
        logic [VB-1:0] mag;
        logic [3:0]    digs [24];
        int            nd;
        t_dec_char     c;
        neg = v[VB-1];
        mag = neg ? (~v + 1'b1) : v;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0);
        if (neg) begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.code = ASCII_ZERO + CHAR_W'(digs[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void push_typed_text(input string txt);
        byte       b;
        t_dec_char c;
        for (int i = 0; i < txt.len(); i++) begin
            b = txt[i];
            c.code = b[CHAR_W-1:0];
            c.last = (i == txt.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic logic [VB-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     k;
        bit     neg;
        neg = $urandom_range(0, 1);
        case ($urandom_range(0, 6))
            0, 1: begin
                return $urandom;
            end
            2, 3: begin
                k = $urandom_range(1, 10);
                lo = 1;
                repeat (k - 1) lo = lo * 10;
                hi = (k == 10) ? 64'd2147483648 : lo * 10 - 1;
                mag = lo + (longint'($urandom) % (hi - lo + 1));
                if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
            end
            4: begin
                mag = $urandom_range(0, 20);
            end
            5: begin
                k = $urandom_range(0, 9);
                mag = 1;
                repeat (k) mag = mag * 10;
                mag = mag + $urandom_range(0, 2) - 1;
            end
            default: begin
                if (neg) return 32'h8000_0000 + $urandom_range(0, 15);
                return 32'h7fff_ffff - $urandom_range(0, 15);
            end
        endcase
        return neg ? VB'(-mag) : VB'(mag);
    endfunction

    task automatic send_value(input logic [VB-1:0] v, input string txt);
        int before_n;
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        before_n = expected_chars.size();
        if (txt.len() != 0) push_typed_text(txt);
        else push_decimal_text(v);
        values_sent++;
        if (v[VB-1]) negatives_sent++;
        if (expected_chars.size() - before_n == 11) full_width_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap != 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pause();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        drain_pauses++;
    endtask

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_value(dir_rows[r].value, dir_rows[r].text);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 120 || n == 330) begin
                drain_pause();
            end
            if (n == 220) begin
                hold_off_req = 1'b1;
                for (int h = 0; h < HOLD_ITEMS; h++) begin
                    send_value(random_value(), "");
                end
            end
            send_value(random_value(), "");
            pace_sender();
        end

        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d characters from %0d values (%0d negative, %0d of eleven chars)",
                 chars_checked, values_sent, negatives_sent, full_width_sent);
        $display("receiver long hold-offs: %0d, sender drain pauses: %0d",
                 hold_offs, drain_pauses);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver stall patterns
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    2: i_stall <= ($urandom_range(0, 9) < 8);
                    default: i_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    // output transaction check
    initial begin
        t_dec_char want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char code %0d last %0b",
                             $time, o_char_code, o_last);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (o_char_code !== want.code) begin
                        $display("%0t: char_code expected %0d actual %0d",
                                 $time, want.code, o_char_code);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, o_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout with %0d chars outstanding",
                         $time, expected_chars.size());
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
